// File: hw/rtl/tkp_pkg.sv
package tkp_pkg;

  // Key mask bits of one scan.
  localparam logic [5:0] K_TIMER = 6'h01;
  localparam logic [5:0] K_LOCK  = 6'h02;
  localparam logic [5:0] K_SPEED = 6'h04;
  localparam logic [5:0] K_POWER = 6'h08;
  localparam logic [5:0] K_ION   = 6'h10;
  localparam logic [5:0] K_AROM  = 6'h20;

  // Hold counter slots.
  localparam int NUM_HOLDS     = 11;
  localparam int H_POWER       = 0;
  localparam int H_SPEED_AROM  = 1;
  localparam int H_SPEED_TIMER = 2;
  localparam int H_POWER_SPEED = 3;
  localparam int H_SPEED       = 4;
  localparam int H_POWER_ION   = 5;
  localparam int H_ION         = 6;
  localparam int H_POWER_AROM  = 7;
  localparam int H_AROM        = 8;
  localparam int H_LOCK        = 9;
  localparam int H_TIMER       = 10;

  // Combination block flags.
  localparam int B_PS = 0;
  localparam int B_PI = 1;
  localparam int B_PA = 2;

  // Event codes.
  localparam logic [3:0] EV_POWER_LONG  = 4'd0;
  localparam logic [3:0] EV_POWER_SHORT = 4'd1;
  localparam logic [3:0] EV_SPEED_AROM  = 4'd2;
  localparam logic [3:0] EV_SPEED_TIMER = 4'd3;
  localparam logic [3:0] EV_POWER_SPEED = 4'd4;
  localparam logic [3:0] EV_SPEED       = 4'd5;
  localparam logic [3:0] EV_POWER_ION   = 4'd6;
  localparam logic [3:0] EV_ION         = 4'd7;
  localparam logic [3:0] EV_POWER_AROM  = 4'd8;
  localparam logic [3:0] EV_AROM        = 4'd9;
  localparam logic [3:0] EV_UNLOCK      = 4'd10;
  localparam logic [3:0] EV_TIMER       = 4'd11;

  // Configuration register indexes.
  localparam logic [2:0] R_DEBOUNCE       = 3'd0;
  localparam logic [2:0] R_SHORT_MIN      = 3'd1;
  localparam logic [2:0] R_LONG_PRESS     = 3'd2;
  localparam logic [2:0] R_LOCK_HOLD      = 3'd3;
  localparam logic [2:0] R_VERSION_HOLD   = 3'd4;
  localparam logic [2:0] R_VERSION_WINDOW = 3'd5;
  localparam logic [2:0] R_IDLE_LOCK      = 3'd6;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;

  // Register defaults after reset.
  localparam logic [15:0] DEF_DEBOUNCE       = 16'd50;
  localparam logic [15:0] DEF_SHORT_MIN      = 16'd50;
  localparam logic [15:0] DEF_LONG_PRESS     = 16'd5000;
  localparam logic [15:0] DEF_LOCK_HOLD      = 16'd3000;
  localparam logic [15:0] DEF_VERSION_HOLD   = 16'd15000;
  localparam logic [15:0] DEF_VERSION_WINDOW = 16'd20000;
  localparam logic [17:0] DEF_IDLE_LOCK      = 18'd180000;

  typedef struct packed {
    logic [5:0] keys;
    logic       powered;
    logic       new_scan;
  } item_t;

  typedef struct packed {
    logic       event_valid;
    logic [3:0] event_res;
    logic       locked;
  } result_t;

  typedef struct packed {
    logic [15:0] debounce_ticks;
    logic [15:0] short_min_ticks;
    logic [15:0] long_press_ticks;
    logic [15:0] lock_hold_ticks;
    logic [15:0] version_hold_ticks;
    logic [15:0] version_window_ticks;
    logic [17:0] idle_lock_ticks;
  } cfg_t;

  typedef struct packed {
    logic [15:0] cnt;
    logic        fired;
    logic        fire;
  } hold_t;

  // One qualifying tick of a hold: saturating count, fires once at threshold.
  function automatic hold_t hold_step(input logic [15:0] cnt, input logic fired,
                                      input logic [15:0] thr);
    hold_t h;
    h.cnt   = cnt;
    h.fired = fired;
    h.fire  = 1'b0;
    if (!fired) begin
      if (cnt != 16'hFFFF) begin
        h.cnt = cnt + 16'd1;
      end
      if (h.cnt >= thr) begin
        h.fired = 1'b1;
        h.fire  = 1'b1;
      end
    end
    return h;
  endfunction

endpackage

// File: hw/rtl/tkp_cfg_regs.sv
module tkp_cfg_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wen,
  input  logic [tkp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tkp_pkg::CFG_DATA_W-1:0] cfg_data,
  output tkp_pkg::cfg_t               cfg
);
  import tkp_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks       <= DEF_DEBOUNCE;
      cfg.short_min_ticks      <= DEF_SHORT_MIN;
      cfg.long_press_ticks     <= DEF_LONG_PRESS;
      cfg.lock_hold_ticks      <= DEF_LOCK_HOLD;
      cfg.version_hold_ticks   <= DEF_VERSION_HOLD;
      cfg.version_window_ticks <= DEF_VERSION_WINDOW;
      cfg.idle_lock_ticks      <= DEF_IDLE_LOCK;
    end else if (cfg_wen) begin
      case (cfg_index)
        R_DEBOUNCE:       cfg.debounce_ticks       <= cfg_data[15:0];
        R_SHORT_MIN:      cfg.short_min_ticks      <= cfg_data[15:0];
        R_LONG_PRESS:     cfg.long_press_ticks     <= cfg_data[15:0];
        R_LOCK_HOLD:      cfg.lock_hold_ticks      <= cfg_data[15:0];
        R_VERSION_HOLD:   cfg.version_hold_ticks   <= cfg_data[15:0];
        R_VERSION_WINDOW: cfg.version_window_ticks <= cfg_data[15:0];
        R_IDLE_LOCK:      cfg.idle_lock_ticks      <= cfg_data[17:0];
        default: ;
      endcase
    end
  end

endmodule

// File: hw/rtl/tkp_classify.sv
module tkp_classify (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  tkp_pkg::item_t   item,
  input  tkp_pkg::cfg_t    cfg,
  output tkp_pkg::result_t result
);
  import tkp_pkg::*;

  logic [NUM_HOLDS-1:0][15:0] cnt;
  logic [NUM_HOLDS-1:0]       fired;
  logic [2:0]                 blk;
  logic [15:0]                uptime;
  logic [17:0]                idle;
  logic                       lock;

  logic [NUM_HOLDS-1:0][15:0] cnt_next;
  logic [NUM_HOLDS-1:0]       fired_next;
  logic [2:0]                 blk_next;
  logic [15:0]                uptime_next;
  logic [17:0]                idle_next;
  logic                       lock_next;
  logic                       unlocked;
  logic                       ev_valid;
  logic [3:0]                 ev;
  hold_t                      h;
  logic [5:0]                 k;

  always_comb begin
    cnt_next    = cnt;
    fired_next  = fired;
    blk_next    = blk;
    uptime_next = uptime;
    idle_next   = idle;
    lock_next   = lock;
    ev_valid    = 1'b0;
    ev          = EV_POWER_LONG;
    h           = '0;
    k           = item.keys;

    if (item.new_scan && k != 6'd0) begin
      idle_next = '0;
    end
    if (idle_next >= cfg.idle_lock_ticks) begin
      lock_next = 1'b1;
    end else if (item.powered) begin
      idle_next = idle_next + 18'd1;
    end
    unlocked = !lock_next;

    // Power key: long press while held, short press on release.
    if (k == K_POWER && blk == 3'd0 && unlocked) begin
      h = hold_step(cnt[H_POWER], fired[H_POWER], cfg.long_press_ticks);
      cnt_next[H_POWER]   = h.cnt;
      fired_next[H_POWER] = h.fired;
      if (h.fire) begin
        ev_valid = 1'b1;
        ev       = EV_POWER_LONG;
      end
    end else begin
      if (k == 6'd0 && cnt[H_POWER] > cfg.short_min_ticks &&
          cnt[H_POWER] < cfg.long_press_ticks) begin
        ev_valid = 1'b1;
        ev       = EV_POWER_SHORT;
      end
      cnt_next[H_POWER]   = '0;
      fired_next[H_POWER] = 1'b0;
    end

    if (uptime < cfg.version_window_ticks) begin
      uptime_next = uptime + 16'd1;
    end

    if (!item.powered) begin
      if (k == (K_SPEED | K_AROM)) begin
        h = hold_step(cnt[H_SPEED_AROM], fired[H_SPEED_AROM], cfg.long_press_ticks);
        cnt_next[H_SPEED_AROM]   = h.cnt;
        fired_next[H_SPEED_AROM] = h.fired;
        if (h.fire) begin
          ev_valid = 1'b1;
          ev       = EV_SPEED_AROM;
        end
      end else begin
        cnt_next[H_SPEED_AROM]   = '0;
        fired_next[H_SPEED_AROM] = 1'b0;
      end
      // The speed-timer hold is never cleared, so it fires once per reset.
      if (k == (K_SPEED | K_TIMER) && uptime_next < cfg.version_window_ticks) begin
        h = hold_step(cnt[H_SPEED_TIMER], fired[H_SPEED_TIMER],
                      cfg.version_hold_ticks);
        cnt_next[H_SPEED_TIMER]   = h.cnt;
        fired_next[H_SPEED_TIMER] = h.fired;
        if (h.fire) begin
          ev_valid = 1'b1;
          ev       = EV_SPEED_TIMER;
        end
      end
    end else begin
      // Power plus speed, then speed alone.
      if (k == (K_POWER | K_SPEED) && unlocked) begin
        h = hold_step(cnt[H_POWER_SPEED], fired[H_POWER_SPEED], cfg.debounce_ticks);
        cnt_next[H_POWER_SPEED]   = h.cnt;
        fired_next[H_POWER_SPEED] = h.fired;
        if (h.fire) begin
          blk_next[B_PS] = 1'b1;
          ev_valid       = 1'b1;
          ev             = EV_POWER_SPEED;
        end
      end else begin
        if ((k & (K_POWER | K_SPEED)) == 6'd0) begin
          blk_next[B_PS] = 1'b0;
        end
        cnt_next[H_POWER_SPEED]   = '0;
        fired_next[H_POWER_SPEED] = 1'b0;
      end
      if (k == K_SPEED && !blk_next[B_PS] && unlocked) begin
        h = hold_step(cnt[H_SPEED], fired[H_SPEED], cfg.debounce_ticks);
        cnt_next[H_SPEED]   = h.cnt;
        fired_next[H_SPEED] = h.fired;
        if (h.fire) begin
          ev_valid = 1'b1;
          ev       = EV_SPEED;
        end
      end else if ((k & K_SPEED) == 6'd0) begin
        cnt_next[H_SPEED]   = '0;
        fired_next[H_SPEED] = 1'b0;
      end

      // Power plus ion, then ion alone.
      if (k == (K_POWER | K_ION) && unlocked) begin
        h = hold_step(cnt[H_POWER_ION], fired[H_POWER_ION], cfg.debounce_ticks);
        cnt_next[H_POWER_ION]   = h.cnt;
        fired_next[H_POWER_ION] = h.fired;
        if (h.fire) begin
          blk_next[B_PI] = 1'b1;
          ev_valid       = 1'b1;
          ev             = EV_POWER_ION;
        end
      end else begin
        if ((k & (K_POWER | K_ION)) == 6'd0) begin
          blk_next[B_PI] = 1'b0;
        end
        cnt_next[H_POWER_ION]   = '0;
        fired_next[H_POWER_ION] = 1'b0;
      end
      if (k == K_ION && !blk_next[B_PI] && unlocked) begin
        h = hold_step(cnt[H_ION], fired[H_ION], cfg.debounce_ticks);
        cnt_next[H_ION]   = h.cnt;
        fired_next[H_ION] = h.fired;
        if (h.fire) begin
          ev_valid = 1'b1;
          ev       = EV_ION;
        end
      end else if ((k & K_ION) == 6'd0) begin
        cnt_next[H_ION]   = '0;
        fired_next[H_ION] = 1'b0;
      end

      // Power plus aroma, then aroma alone.
      if (k == (K_POWER | K_AROM) && unlocked) begin
        h = hold_step(cnt[H_POWER_AROM], fired[H_POWER_AROM], cfg.debounce_ticks);
        cnt_next[H_POWER_AROM]   = h.cnt;
        fired_next[H_POWER_AROM] = h.fired;
        if (h.fire) begin
          blk_next[B_PA] = 1'b1;
          ev_valid       = 1'b1;
          ev             = EV_POWER_AROM;
        end
      end else begin
        if ((k & (K_POWER | K_AROM)) == 6'd0) begin
          blk_next[B_PA] = 1'b0;
        end
        cnt_next[H_POWER_AROM]   = '0;
        fired_next[H_POWER_AROM] = 1'b0;
      end
      if (k == K_AROM && !blk_next[B_PA] && unlocked) begin
        h = hold_step(cnt[H_AROM], fired[H_AROM], cfg.debounce_ticks);
        cnt_next[H_AROM]   = h.cnt;
        fired_next[H_AROM] = h.fired;
        if (h.fire) begin
          ev_valid = 1'b1;
          ev       = EV_AROM;
        end
      end else if ((k & K_AROM) == 6'd0) begin
        cnt_next[H_AROM]   = '0;
        fired_next[H_AROM] = 1'b0;
      end

      // The lock key counts even when already unlocked.
      if (k == K_LOCK) begin
        h = hold_step(cnt[H_LOCK], fired[H_LOCK], cfg.lock_hold_ticks);
        cnt_next[H_LOCK]   = h.cnt;
        fired_next[H_LOCK] = h.fired;
        if (h.fire) begin
          lock_next = 1'b0;
          idle_next = '0;
          ev_valid  = 1'b1;
          ev        = EV_UNLOCK;
        end
      end else if ((k & K_LOCK) == 6'd0) begin
        cnt_next[H_LOCK]   = '0;
        fired_next[H_LOCK] = 1'b0;
      end

      if (k == K_TIMER && unlocked) begin
        h = hold_step(cnt[H_TIMER], fired[H_TIMER], cfg.debounce_ticks);
        cnt_next[H_TIMER]   = h.cnt;
        fired_next[H_TIMER] = h.fired;
        if (h.fire) begin
          ev_valid = 1'b1;
          ev       = EV_TIMER;
        end
      end else if ((k & K_TIMER) == 6'd0) begin
        cnt_next[H_TIMER]   = '0;
        fired_next[H_TIMER] = 1'b0;
      end
    end

    result.event_valid = ev_valid;
    result.event_res   = ev_valid ? ev : EV_POWER_LONG;
    result.locked      = lock_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= '0;
      fired  <= '0;
      blk    <= '0;
      uptime <= '0;
      idle   <= '0;
      lock   <= 1'b0;
    end else if (step) begin
      cnt    <= cnt_next;
      fired  <= fired_next;
      blk    <= blk_next;
      uptime <= uptime_next;
      idle   <= idle_next;
      lock   <= lock_next;
    end
  end

endmodule

// File: hw/rtl/touch_key_press_classifier_unit.sv
// Touch-key press classifier: one result item for every tick item.
// The item is held in the input register, then its result is loaded into the result register.
// Throughput: one item per cycle while the result side does not stall; the hold and lock update is combinational.
// A waiting result does not block the next item, which the input register holds; a further item then stalls.
// Synchronous reset clears all hold state and loads the register defaults.
module touch_key_press_classifier_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           item_valid,
  output logic                           item_stall,
  input  tkp_pkg::item_t                 item,
  output logic                           result_valid,
  input  logic                           result_stall,
  output tkp_pkg::result_t               result,
  input  logic                           cfg_wen,
  input  logic [tkp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tkp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tkp_pkg::*;

  cfg_t    cfg;
  item_t   item_q;
  logic    item_q_valid;
  result_t core_result;
  logic    advance;
  logic    accept;

  assign advance    = !result_valid || !result_stall;
  assign item_stall = item_q_valid && !advance;
  assign accept     = item_valid && !item_stall;

  tkp_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tkp_classify u_classify (
    .clk    (clk),
    .rst    (rst),
    .step   (item_q_valid && advance),
    .item   (item_q),
    .cfg    (cfg),
    .result (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_q_valid <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (accept) begin
        item_q_valid <= 1'b1;
      end else if (advance) begin
        item_q_valid <= 1'b0;
      end
      if (advance) begin
        result_valid <= item_q_valid;
      end
    end
    if (accept) begin
      item_q <= item;
    end
    if (advance && item_q_valid) begin
      result <= core_result;
    end
  end

endmodule

// File: tb/sv/touch_key_press_classifier_unit_tb.sv
`timescale 1ns / 100ps

module touch_key_press_classifier_unit_tb;
  import tkp_pkg::*;

  // Writes to this index must be ignored by the block.
  localparam logic [CFG_IDX_W-1:0] R_UNUSED = 3'd7;

  // Tracks the key hold state and the expected event of every tick item.
  class press_event_tracker;
    logic [15:0]          hold_cnt [NUM_HOLDS];
    logic [NUM_HOLDS-1:0] fired;
    logic [2:0]           blocked;
    logic [15:0]          uptime_ticks;
    logic [17:0]          idle_ticks;
    logic                 locked_now;
    cfg_t                 regs;
    result_t              expected_events[$];
    int                   mismatches;

    function new();
      regs.debounce_ticks       = DEF_DEBOUNCE;
      regs.short_min_ticks      = DEF_SHORT_MIN;
      regs.long_press_ticks     = DEF_LONG_PRESS;
      regs.lock_hold_ticks      = DEF_LOCK_HOLD;
      regs.version_hold_ticks   = DEF_VERSION_HOLD;
      regs.version_window_ticks = DEF_VERSION_WINDOW;
      regs.idle_lock_ticks      = DEF_IDLE_LOCK;
      foreach (hold_cnt[i]) hold_cnt[i] = 16'd0;
      fired        = '0;
      blocked      = '0;
      uptime_ticks = '0;
      idle_ticks   = '0;
      locked_now   = 1'b0;
      mismatches   = 0;
    endfunction

    function void load_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        R_DEBOUNCE:       regs.debounce_ticks       = val[15:0];
        R_SHORT_MIN:      regs.short_min_ticks      = val[15:0];
        R_LONG_PRESS:     regs.long_press_ticks     = val[15:0];
        R_LOCK_HOLD:      regs.lock_hold_ticks      = val[15:0];
        R_VERSION_HOLD:   regs.version_hold_ticks   = val[15:0];
        R_VERSION_WINDOW: regs.version_window_ticks = val[15:0];
        R_IDLE_LOCK:      regs.idle_lock_ticks      = val[17:0];
        default: ;
      endcase
    endfunction

    // One qualifying tick of a hold; true on the tick that it fires.
    function bit count_hold(int k, logic [15:0] thr);
      if (fired[k]) return 1'b0;
      if (hold_cnt[k] != 16'hFFFF) hold_cnt[k] = hold_cnt[k] + 16'd1;
      if (hold_cnt[k] >= thr) begin
        fired[k] = 1'b1;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void drop_hold(int k);
      fired[k]    = 1'b0;
      hold_cnt[k] = 16'd0;
    endfunction

    // A power combination and its single key share a block flag.
    function void pair_tick(input logic [5:0] k, input bit unl, input logic [5:0] key,
                            input int hc, input int hs, input int b,
                            input logic [3:0] code_c, input logic [3:0] code_s,
                            inout bit ev_v, inout logic [3:0] ev);
      if (k == (K_POWER | key) && unl) begin
        if (count_hold(hc, regs.debounce_ticks)) begin
          blocked[b] = 1'b1;
          ev_v = 1'b1;
          ev   = code_c;
        end
      end else begin
        if ((k & (K_POWER | key)) == 6'd0) blocked[b] = 1'b0;
        drop_hold(hc);
      end
      if (k == key && !blocked[b] && unl) begin
        if (count_hold(hs, regs.debounce_ticks)) begin
          ev_v = 1'b1;
          ev   = code_s;
        end
      end else if ((k & key) == 6'd0) begin
        drop_hold(hs);
      end
    endfunction

    function void note_item(item_t it);
      logic [5:0] k;
      bit         unl;
      bit         ev_v;
      logic [3:0] ev;
      result_t    r;
      k    = it.keys;
      ev_v = 1'b0;
      ev   = EV_POWER_LONG;

      if (it.new_scan && k != 6'd0) idle_ticks = '0;
      if (idle_ticks >= regs.idle_lock_ticks) locked_now = 1'b1;
      else if (it.powered) idle_ticks = idle_ticks + 18'd1;
      unl = !locked_now;

      if (k == K_POWER && blocked == 3'b000 && unl) begin
        if (count_hold(H_POWER, regs.long_press_ticks)) begin
          ev_v = 1'b1;
          ev   = EV_POWER_LONG;
        end
      end else begin
        if (k == 6'd0 && hold_cnt[H_POWER] > regs.short_min_ticks &&
            hold_cnt[H_POWER] < regs.long_press_ticks) begin
          ev_v = 1'b1;
          ev   = EV_POWER_SHORT;
        end
        drop_hold(H_POWER);
      end

      if (uptime_ticks < regs.version_window_ticks) uptime_ticks = uptime_ticks + 16'd1;

      if (!it.powered) begin
        // Apart from the power key hold, only the power-off combinations move; the rest keep their state.
        if (k == (K_SPEED | K_AROM)) begin
          if (count_hold(H_SPEED_AROM, regs.long_press_ticks)) begin
            ev_v = 1'b1;
            ev   = EV_SPEED_AROM;
          end
        end else begin
          drop_hold(H_SPEED_AROM);
        end
        // The version combination is never cleared, so it fires once per reset.
        if (k == (K_SPEED | K_TIMER) && uptime_ticks < regs.version_window_ticks) begin
          if (count_hold(H_SPEED_TIMER, regs.version_hold_ticks)) begin
            ev_v = 1'b1;
            ev   = EV_SPEED_TIMER;
          end
        end
      end else begin
        pair_tick(k, unl, K_SPEED, H_POWER_SPEED, H_SPEED, B_PS,
                  EV_POWER_SPEED, EV_SPEED, ev_v, ev);
        pair_tick(k, unl, K_ION, H_POWER_ION, H_ION, B_PI,
                  EV_POWER_ION, EV_ION, ev_v, ev);
        pair_tick(k, unl, K_AROM, H_POWER_AROM, H_AROM, B_PA,
                  EV_POWER_AROM, EV_AROM, ev_v, ev);
        if (k == K_LOCK) begin
          if (count_hold(H_LOCK, regs.lock_hold_ticks)) begin
            locked_now = 1'b0;
            idle_ticks = '0;
            ev_v = 1'b1;
            ev   = EV_UNLOCK;
          end
        end else if ((k & K_LOCK) == 6'd0) begin
          drop_hold(H_LOCK);
        end
        if (k == K_TIMER && unl) begin
          if (count_hold(H_TIMER, regs.debounce_ticks)) begin
            ev_v = 1'b1;
            ev   = EV_TIMER;
          end
        end else if ((k & K_TIMER) == 6'd0) begin
          drop_hold(H_TIMER);
        end
      end

      r.event_valid = ev_v;
      r.event_res   = ev_v ? ev : EV_POWER_LONG;
      r.locked      = locked_now;
      expected_events.push_back(r);
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      mismatches++;
    endtask

    task check(result_t got);
      result_t want;
      if (expected_events.size() == 0) begin
        report($sformatf("result %h arrived with no item waiting", got));
      end else begin
        want = expected_events.pop_front();
        if (got.event_valid !== want.event_valid)
          report($sformatf("event_valid %b, expected %b", got.event_valid, want.event_valid));
        if (got.event_res !== want.event_res)
          report($sformatf("event_res %0d, expected %0d", got.event_res, want.event_res));
        if (got.locked !== want.locked)
          report($sformatf("locked %b, expected %b", got.locked, want.locked));
      end
    endtask

    function int pending();
      return expected_events.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  item_valid;
  logic                  item_stall;
  item_t                 item;
  logic                  result_valid;
  logic                  result_stall;
  result_t               result;
  logic                  cfg_wen;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  press_event_tracker tracker = new();

  int tx_idle_pct;
  int rx_idle_pct;
  int hold_off_asks;
  int hold_off_done;
  int hold_left;

  touch_key_press_classifier_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_wen      (cfg_wen),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Result side: random stall, plus a long hold-off whenever one is asked for.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      result_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else if (hold_off_asks != hold_off_done) begin
      hold_off_done = hold_off_asks;
      hold_left = 80;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // Inputs are noted before results, since a result never leaves on its own item's edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (item_valid && !item_stall) tracker.note_item(item);
      if (result_valid && !result_stall) tracker.check(result);
    end
  end

  task automatic send_item(input item_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
  endtask

  task automatic tick(input logic [5:0] k, input logic pwr, input logic scan);
    item_t it;
    it.keys     = k;
    it.powered  = pwr;
    it.new_scan = scan;
    send_item(it);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    tracker.load_reg(idx, val);
  endtask

  // One edge first, so that the last accepted item is already counted.
  task automatic wait_drained();
    item_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  // The upper data bits of the 16-bit registers carry junk that must be dropped.
  task automatic program_regs(input int deb, input int shrt, input int lng, input int lockh,
                              input int verh, input int win, input int idle);
    write_reg(R_DEBOUNCE,       {2'($urandom), 16'(deb)});
    write_reg(R_SHORT_MIN,      {2'($urandom), 16'(shrt)});
    write_reg(R_LONG_PRESS,     {2'($urandom), 16'(lng)});
    write_reg(R_LOCK_HOLD,      {2'($urandom), 16'(lockh)});
    write_reg(R_VERSION_HOLD,   {2'($urandom), 16'(verh)});
    write_reg(R_VERSION_WINDOW, {2'($urandom), 16'(win)});
    write_reg(R_IDLE_LOCK,      18'(idle));
    write_reg(R_UNUSED,         18'($urandom));
    cfg_wen <= 1'b0;
  endtask

  function automatic logic [5:0] pick_keys();
    case ($urandom_range(13))
      0:       return K_POWER;
      1:       return K_POWER | K_SPEED;
      2:       return K_SPEED;
      3:       return K_POWER | K_ION;
      4:       return K_ION;
      5:       return K_POWER | K_AROM;
      6:       return K_AROM;
      7:       return K_LOCK;
      8:       return K_TIMER;
      9:       return K_SPEED | K_AROM;
      10:      return K_SPEED | K_TIMER;
      11:      return 6'd0;
      default: return 6'($urandom);
    endcase
  endfunction

  // Presses held for random lengths around the thresholds, with releases between.
  task automatic run_presses(input int n_items, input int span, input int gap_span,
                             input bit squeeze);
    int         sent;
    int         len;
    logic [5:0] pat;
    bit         pwr;
    item_t      it;
    sent = 0;
    while (sent < n_items) begin
      pat = pick_keys();
      pwr = ($urandom_range(99) < 80);
      len = $urandom_range(span, 1);
      repeat (len) begin
        it.keys     = ($urandom_range(99) < 4) ? 6'($urandom) : pat;
        it.powered  = ($urandom_range(99) < 3) ? !pwr : pwr;
        it.new_scan = ($urandom_range(99) < 85);
        send_item(it);
        sent++;
        if (squeeze && sent == 50) hold_off_asks <= hold_off_asks + 1;
      end
      if ($urandom_range(99) < 75) begin
        repeat ($urandom_range(gap_span)) begin
          it.keys     = 6'd0;
          it.powered  = pwr;
          it.new_scan = ($urandom_range(99) < 85);
          send_item(it);
          sent++;
          if (squeeze && sent == 50) hold_off_asks <= hold_off_asks + 1;
        end
      end
    end
  endtask

  initial begin
    rst           <= 1'b1;
    item_valid    <= 1'b0;
    item          <= '0;
    cfg_wen       <= 1'b0;
    cfg_index     <= '0;
    cfg_data      <= '0;
    result_stall  <= 1'b0;
    hold_off_asks <= 0;
    hold_off_done = 0;
    hold_left     = 0;
    tx_idle_pct   = 37;
    rx_idle_pct   = 74;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Short thresholds so that every event fires within a few ticks.
    program_regs(1, 0, 3, 1, 1, 65535, 262143);
    tick(6'd0, 1'b0, 1'b0);
    tick(K_SPEED | K_TIMER, 1'b0, 1'b1);
    repeat (3) tick(K_SPEED | K_AROM, 1'b0, 1'b1);
    tick(6'd0, 1'b1, 1'b1);
    tick(K_POWER, 1'b1, 1'b1);
    tick(6'd0, 1'b1, 1'b1);
    repeat (3) tick(K_POWER, 1'b1, 1'b1);
    tick(6'd0, 1'b1, 1'b1);
    tick(K_POWER | K_SPEED, 1'b1, 1'b1);
    // Speed alone stays blocked until both keys of the combination are up.
    tick(K_SPEED, 1'b1, 1'b1);
    tick(6'd0, 1'b1, 1'b1);
    tick(K_SPEED, 1'b1, 1'b1);
    tick(K_POWER | K_ION, 1'b1, 1'b1);
    tick(6'd0, 1'b1, 1'b1);
    tick(K_ION, 1'b1, 1'b1);
    tick(K_POWER | K_AROM, 1'b1, 1'b1);
    tick(6'd0, 1'b1, 1'b1);
    tick(K_AROM, 1'b1, 1'b1);
    // The lock key fires even while the block is unlocked.
    tick(K_LOCK, 1'b1, 1'b1);
    tick(K_TIMER, 1'b1, 1'b1);
    tick(6'h3F, 1'b1, 1'b1);
    wait_drained();

    program_regs(3, 2, 12, 5, 20, 65535, 40);
    run_presses(290, 16, 50, 1'b0);
    wait_drained();

    // Zero thresholds fire on the first qualifying tick.
    program_regs(0, 0, 0, 0, 0, 0, 1);
    run_presses(290, 3, 5, 1'b0);
    wait_drained();

    tx_idle_pct = 74;
    rx_idle_pct = 37;
    program_regs(65535, 65535, 65535, 65535, 65535, 65535, 262143);
    run_presses(290, 20, 10, 1'b0);
    wait_drained();

    program_regs(6, 4, 25, 10, 8, 300, 80);
    run_presses(290, 30, 90, 1'b0);
    wait_drained();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    program_regs(2, 1, 8, 3, 4, 20000, 150);
    run_presses(290, 12, 160, 1'b1);
    wait_drained();

    repeat (8) @(posedge clk);
    if (tracker.pending() != 0)
      tracker.report($sformatf("%0d results never arrived", tracker.pending()));
    if (tracker.mismatches == 0) begin
      $display("touch_key_press_classifier_unit_tb passed");
    end else begin
      $display("touch_key_press_classifier_unit_tb failed");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("touch_key_press_classifier_unit_tb failed");
    $finish;
  end

endmodule

// File: files.f
hw/rtl/tkp_pkg.sv
hw/rtl/tkp_cfg_regs.sv
hw/rtl/tkp_classify.sv
hw/rtl/touch_key_press_classifier_unit.sv
tb/sv/touch_key_press_classifier_unit_tb.sv
